// ----- rtl/flsc_pkg.sv -----
// Shared types, codes, constants and helpers of the flash LED strobe controller.
package flsc_pkg;

    // Burst timing.
    localparam logic [8:0]  PERIOD_TICKS  = 9'd200;   // ticks per burst period
    localparam logic [11:0] BURST_PERIODS = 12'd2500; // 500 * 1000 / 200 periods
    localparam logic [3:0]  DUTY_MAX      = 4'd6;

    // High time per period is (HIGH_BASE + HIGH_STEP * duty) * HIGH_SCALE ticks.
    localparam logic [8:0]  HIGH_BASE     = 9'd40;
    localparam logic [8:0]  HIGH_STEP     = 9'd10;
    localparam logic [8:0]  HIGH_SCALE    = 9'd2;

    localparam logic [31:0] DELAY_RESET   = 32'd1000;
    localparam logic [3:0]  DUTY_UNSET    = 4'hF;     // -1 in four bits

    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_DUTY  = 3'd1,
        KIND_DELAY = 3'd2,
        KIND_ON    = 3'd3,
        KIND_OFF   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_TORCH = 2'd1,
        MODE_FLASH = 2'd2
    } t_led_mode;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
    } t_item;

    typedef struct packed {
        logic        flash_pin;
        logic        torch_pin;
        t_led_mode   led_mode;
        logic [3:0]  duty_readback;
        logic [31:0] delay_readback;
        logic        burst_running;
    } t_result;

    // High time of a burst period for a non-negative duty, limited to one period.
    function automatic logic [7:0] f_high_ticks(input logic [2:0] duty,
                                                input logic [8:0] limit);
        logic [8:0] h;
        h = (HIGH_BASE + HIGH_STEP * {6'd0, duty}) * HIGH_SCALE;
        if (h > limit) begin
            h = limit;
        end
        return h[7:0];
    endfunction

endpackage

// ----- rtl/flsc_in_if.sv -----
// Command and tick channel: valid/ready handshake with kind and value payload.
interface flsc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- rtl/flsc_out_if.sv -----
// Status channel: valid/ready handshake with pin, mode, duty, delay and burst payload.
interface flsc_out_if;
    logic              valid;
    logic              ready;
    logic              flash_pin;
    logic              torch_pin;
    logic [1:0]        led_mode;
    logic signed [3:0] duty_readback;
    logic [31:0]       delay_readback;
    logic              burst_running;

    modport source (output valid, output flash_pin, output torch_pin, output led_mode,
                    output duty_readback, output delay_readback, output burst_running,
                    input ready);
    modport sink   (input valid, input flash_pin, input torch_pin, input led_mode,
                    input duty_readback, input delay_readback, input burst_running,
                    output ready);
endinterface

// ----- rtl/flsc_in_stage.sv -----
// Input register: captures one command beat and holds it until the core takes it.
module flsc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    flsc_in_if.sink        i_in,
    input  logic           i_advance,
    output logic           o_valid,
    output flsc_pkg::t_item o_item
);
    import flsc_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign i_in.ready = !r_valid || i_advance;
    assign load       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.kind  <= t_kind'(i_in.kind);
            r_item.value <= i_in.value;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ----- rtl/flsc_core.sv -----
// Controller state and its single-pass update for one command or tick.
module flsc_core #(
    parameter logic [8:0]  PERIOD_TICKS  = flsc_pkg::PERIOD_TICKS,
    parameter logic [11:0] BURST_PERIODS = flsc_pkg::BURST_PERIODS,
    parameter logic [3:0]  DUTY_MAX      = flsc_pkg::DUTY_MAX
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  flsc_pkg::t_item   i_item,
    output flsc_pkg::t_result o_result
);
    import flsc_pkg::*;

    t_led_mode   r_mode,  n_mode;
    logic [3:0]  r_duty,  n_duty;
    logic [31:0] r_delay, n_delay;
    logic [31:0] r_rem,   n_rem;
    logic        r_armed, n_armed;
    logic [11:0] r_count, n_count;
    logic [7:0]  r_phase, n_phase;
    logic        r_burst, n_burst;
    logic        r_flash, n_flash;
    logic        r_torch, n_torch;
    logic [7:0]  r_high,  n_high;

    logic [8:0]  phase_inc;
    logic [11:0] count_inc;
    logic [2:0]  duty_pos;

    assign phase_inc = {1'b0, r_phase} + 9'd1;
    assign count_inc = r_count + 12'd1;
    // Unset duty counts as zero.
    assign duty_pos  = r_duty[3] ? 3'd0 : r_duty[2:0];

    always_comb begin
        n_mode  = r_mode;
        n_duty  = r_duty;
        n_delay = r_delay;
        n_rem   = r_rem;
        n_armed = r_armed;
        n_count = r_count;
        n_phase = r_phase;
        n_burst = r_burst;
        n_flash = r_flash;
        n_torch = r_torch;
        n_high  = r_high;
        if (i_fire) begin
            case (i_item.kind)
                KIND_TICK: begin
                    if (r_burst) begin
                        if (phase_inc >= PERIOD_TICKS) begin
                            n_phase = 8'd0;
                            n_count = count_inc;
                        end else begin
                            n_phase = phase_inc[7:0];
                        end
                        if (n_count >= BURST_PERIODS) begin
                            n_burst = 1'b0;
                            n_count = 12'd0;
                            n_phase = 8'd0;
                            n_flash = 1'b0;
                        end else begin
                            n_flash = n_phase < r_high;
                        end
                    end
                    if (r_armed) begin
                        if (r_rem <= 32'd1) begin
                            n_armed = 1'b0;
                            n_rem   = 32'd0;
                            if (r_mode == MODE_FLASH) begin
                                // Restart the burst and latch its high time.
                                n_high  = f_high_ticks(duty_pos, PERIOD_TICKS);
                                n_burst = 1'b1;
                                n_count = 12'd0;
                                n_phase = 8'd0;
                                n_flash = n_high != 8'd0;
                            end else if (r_mode == MODE_TORCH) begin
                                n_torch = 1'b1;
                            end
                        end else begin
                            n_rem = r_rem - 32'd1;
                        end
                    end
                end
                KIND_DUTY: begin
                    n_duty = (i_item.value > {28'd0, DUTY_MAX}) ? DUTY_MAX
                                                                : i_item.value[3:0];
                end
                KIND_DELAY: begin
                    n_delay = i_item.value;
                end
                KIND_ON: begin
                    n_mode = (!r_duty[3] && r_duty != 4'd0) ? MODE_FLASH : MODE_TORCH;
                    if (n_mode != MODE_FLASH && r_burst) begin
                        n_burst = 1'b0;
                        n_count = 12'd0;
                        n_phase = 8'd0;
                        n_flash = 1'b0;
                    end
                    n_rem   = r_delay;
                    n_armed = 1'b1;
                end
                KIND_OFF: begin
                    if (r_mode != MODE_OFF) begin
                        n_mode  = MODE_OFF;
                        n_duty  = DUTY_UNSET;
                        n_delay = 32'd0;
                        n_rem   = 32'd0;
                        n_armed = 1'b0;
                        n_burst = 1'b0;
                        n_count = 12'd0;
                        n_phase = 8'd0;
                        n_flash = 1'b0;
                        n_torch = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OFF;
            r_duty  <= DUTY_UNSET;
            r_delay <= DELAY_RESET;
            r_rem   <= 32'd0;
            r_armed <= 1'b0;
            r_count <= 12'd0;
            r_phase <= 8'd0;
            r_burst <= 1'b0;
            r_flash <= 1'b0;
            r_torch <= 1'b0;
            r_high  <= 8'd0;
        end else begin
            r_mode  <= n_mode;
            r_duty  <= n_duty;
            r_delay <= n_delay;
            r_rem   <= n_rem;
            r_armed <= n_armed;
            r_count <= n_count;
            r_phase <= n_phase;
            r_burst <= n_burst;
            r_flash <= n_flash;
            r_torch <= n_torch;
            r_high  <= n_high;
        end
    end

    // Report the state after the update.
    always_comb begin
        o_result.flash_pin      = n_flash;
        o_result.torch_pin      = n_torch;
        o_result.led_mode       = n_mode;
        o_result.duty_readback  = n_duty;
        o_result.delay_readback = n_delay;
        o_result.burst_running  = n_burst;
    end
endmodule

// ----- rtl/flsc_out_stage.sv -----
// Result register: holds one status beat until the sink takes it.
module flsc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  flsc_pkg::t_result i_result,
    output logic              o_can_load,
    flsc_out_if.source        o_out
);
    import flsc_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.flash_pin      = r_result.flash_pin;
    assign o_out.torch_pin      = r_result.torch_pin;
    assign o_out.led_mode       = 2'(r_result.led_mode);
    assign o_out.duty_readback  = $signed(r_result.duty_readback);
    assign o_out.delay_readback = r_result.delay_readback;
    assign o_out.burst_running  = r_result.burst_running;
endmodule

// ----- rtl/flash_led_strobe_controller_unit.sv -----
// Top level of the flash LED strobe controller: input register, core, result register.
//
//  channel | dir | payload                                               | handshake
//  --------+-----+-------------------------------------------------------+-------------
//  i_in    | in  | kind[2:0], value[31:0]                                | valid/ready
//  o_out   | out | flash_pin, torch_pin, led_mode[1:0], duty_readback[3:0],
//          |     | delay_readback[31:0], burst_running                   | valid/ready
//
//  Each beat passes from acceptance through the input register, then through the core
//  update into the result register. A new beat is accepted every cycle unless o_out
//  stalls; the core state update is the single loop.
//  Reset (i_rst_n low at a clock edge) sets mode off, duty unset, delay 1000, no burst.
//  A stalled o_out holds its beat; the input register then holds one more, and
//  i_in.ready drops only when both are full.
module flash_led_strobe_controller_unit #(
    parameter logic [8:0]  PERIOD_TICKS  = flsc_pkg::PERIOD_TICKS,
    parameter logic [11:0] BURST_PERIODS = flsc_pkg::BURST_PERIODS,
    parameter logic [3:0]  DUTY_MAX      = flsc_pkg::DUTY_MAX
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    flsc_in_if.sink    i_in,
    flsc_out_if.source o_out
);
    import flsc_pkg::*;

    logic    item_valid;
    t_item   item;
    t_result result;
    logic    can_load;
    logic    advance;

    // Advance the held beat through the core when the result register has room.
    assign advance = item_valid && can_load;

    flsc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    // Update state only for the beat that advances; report the new state.
    flsc_core #(
        .PERIOD_TICKS  (PERIOD_TICKS),
        .BURST_PERIODS (BURST_PERIODS),
        .DUTY_MAX      (DUTY_MAX)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (item),
        .o_result (result)
    );

    flsc_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (result),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    // A burst only runs in flash mode.
    a_burst_in_flash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.burst_running |-> o_out.led_mode == MODE_FLASH)
        else $error("burst reported outside flash mode");

    // The flash pin pulses only inside a burst.
    a_flash_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.flash_pin |-> o_out.burst_running)
        else $error("flash pin high without a burst");

    // Duty reads back as unset or a clamped level.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.duty_readback == DUTY_UNSET ||
                         (!o_out.duty_readback[3] && o_out.duty_readback <= DUTY_MAX)))
        else $error("duty readback out of range");

    // An advancing beat always leaves a status beat behind.
    a_advance_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out.valid)
        else $error("advanced beat produced no status beat");
endmodule
